// ===== hw/rtl/ffd_pkg.sv =====
// Shared constants and types for the fixed frame deframer with sum check.
package ffd_pkg;

  localparam int FRAME_BYTES = 56;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int INDEX_W     = 6;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t LAST_POS  = addr_t'(FRAME_BYTES - 1);
  localparam addr_t CHECK_POS = addr_t'(FRAME_BYTES - 2);
  localparam addr_t SUM_END   = addr_t'(FRAME_BYTES - 3);
  localparam addr_t TYPE_POS  = addr_t'(2);
  localparam addr_t LEN_POS   = addr_t'(3);

  localparam logic [7:0] HDR0_BYTE = 8'hAA;
  localparam logic [7:0] HDR1_BYTE = 8'h55;
  localparam logic [7:0] TYPE_BYTE = 8'h02;
  localparam logic [7:0] LEN_BYTE  = 8'h36;
  localparam logic [7:0] TAIL_BYTE = 8'h5A;

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_WAIT_HDR1,
    PH_COLLECT
  } sync_phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EMIT_RD,
    SEQ_EMIT_WAIT
  } seq_t;

endpackage

// ===== hw/rtl/fixed_frame_deframer_sum_check_unit.sv =====
// Top level of the fixed frame deframer: header hunt, frame store, sum check and replay.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid / rx_stall  rx_byte
//   res      out        res_valid / res_stall frame_status, frame_byte, byte_index, last
//
// Each received byte gives one status beat, except the byte that completes a valid
// frame, which starts a replay of the stored frame.
// The replay reads the frame memory through its single read port: a read-start state
// (SEQ_EMIT_RD), then one beat per cycle while the output is free, with rx_stall held high throughout.
// A held res_stall stalls the input once the output register is full and pauses the replay.
// Reset clears the phase, the sequencer, the fill index, the sum and the output valid; the memory keeps its data.
module fixed_frame_deframer_sum_check_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] frame_status,
  output logic [7:0] frame_byte,
  output logic [ffd_pkg::INDEX_W-1:0] byte_index,
  output logic       last
);

  logic [7:0] frame_store [ffd_pkg::FRAME_BYTES];
  logic [7:0] mem_q;

  ffd_pkg::sync_phase_t phase, phase_next;
  ffd_pkg::seq_t        seq, seq_next;
  ffd_pkg::addr_t       fill_index, fill_index_next;
  ffd_pkg::addr_t       emit_index, emit_index_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [7:0]           check_byte, check_byte_next;
  logic                 type_ok, type_ok_next;
  logic                 len_ok, len_ok_next;

  logic                 we, re;
  ffd_pkg::addr_t       waddr, raddr;
  logic                 rx_take, out_free, out_load;
  logic [1:0]           load_status;
  logic [7:0]           load_byte;
  ffd_pkg::addr_t       load_index;
  logic                 load_last;

  assign out_free = !res_valid || !res_stall;
  assign rx_stall = (seq != ffd_pkg::SEQ_IDLE) || !out_free;
  assign rx_take  = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ffd_pkg::PH_HUNT;
      seq         <= ffd_pkg::SEQ_IDLE;
      fill_index  <= '0;
      running_sum <= '0;
      res_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      seq         <= seq_next;
      fill_index  <= fill_index_next;
      running_sum <= running_sum_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_index <= emit_index_next;
    check_byte <= check_byte_next;
    type_ok    <= type_ok_next;
    len_ok     <= len_ok_next;
    if (out_load) begin
      frame_status <= load_status;
      frame_byte   <= load_byte;
      byte_index   <= ffd_pkg::INDEX_W'(load_index);
      last         <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      frame_store[waddr] <= rx_byte;
    end
    if (re) begin
      mem_q <= frame_store[raddr];
    end
  end

  always_comb begin
    phase_next       = phase;
    seq_next         = seq;
    fill_index_next  = fill_index;
    emit_index_next  = emit_index;
    running_sum_next = running_sum;
    check_byte_next  = check_byte;
    type_ok_next     = type_ok;
    len_ok_next      = len_ok;
    we               = 1'b0;
    waddr            = fill_index;
    re               = 1'b0;
    raddr            = '0;
    out_load         = 1'b0;
    load_status      = ffd_pkg::ST_PENDING;
    load_byte        = '0;
    load_index       = '0;
    load_last        = 1'b1;

    unique case (seq)
      ffd_pkg::SEQ_IDLE: begin
        if (rx_take) begin
          out_load = 1'b1;
          unique case (phase)
            ffd_pkg::PH_HUNT: begin
              if (rx_byte == ffd_pkg::HDR0_BYTE) begin
                we         = 1'b1;
                waddr      = '0;
                phase_next = ffd_pkg::PH_WAIT_HDR1;
              end
            end
            ffd_pkg::PH_WAIT_HDR1: begin
              if (rx_byte == ffd_pkg::HDR1_BYTE) begin
                we               = 1'b1;
                waddr            = ffd_pkg::addr_t'(1);
                fill_index_next  = ffd_pkg::addr_t'(2);
                running_sum_next = '0;
                phase_next       = ffd_pkg::PH_COLLECT;
              end else if (rx_byte != ffd_pkg::HDR0_BYTE) begin
                phase_next = ffd_pkg::PH_HUNT;
              end
            end
            ffd_pkg::PH_COLLECT: begin
              we = 1'b1;
              if (fill_index >= ffd_pkg::TYPE_POS && fill_index <= ffd_pkg::SUM_END) begin
                running_sum_next = running_sum + rx_byte;
              end
              if (fill_index == ffd_pkg::TYPE_POS) begin
                type_ok_next = (rx_byte == ffd_pkg::TYPE_BYTE);
              end
              if (fill_index == ffd_pkg::LEN_POS) begin
                len_ok_next = (rx_byte == ffd_pkg::LEN_BYTE);
              end
              if (fill_index == ffd_pkg::CHECK_POS) begin
                check_byte_next = rx_byte;
              end
              if (fill_index >= ffd_pkg::LAST_POS) begin
                phase_next      = ffd_pkg::PH_HUNT;
                fill_index_next = '0;
                if (type_ok && len_ok && rx_byte == ffd_pkg::TAIL_BYTE &&
                    running_sum == check_byte) begin
                  out_load = 1'b0;
                  seq_next = ffd_pkg::SEQ_EMIT_RD;
                end else begin
                  load_status = ffd_pkg::ST_INVALID;
                end
              end else begin
                fill_index_next = fill_index + 1'b1;
              end
            end
            default: begin
              phase_next = ffd_pkg::PH_HUNT;
            end
          endcase
        end
      end
      ffd_pkg::SEQ_EMIT_RD: begin
        re              = 1'b1;
        raddr           = '0;
        emit_index_next = '0;
        seq_next        = ffd_pkg::SEQ_EMIT_WAIT;
      end
      ffd_pkg::SEQ_EMIT_WAIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_status = ffd_pkg::ST_VALID;
          load_byte   = mem_q;
          load_index  = emit_index;
          load_last   = (emit_index == ffd_pkg::LAST_POS);
          if (emit_index == ffd_pkg::LAST_POS) begin
            seq_next = ffd_pkg::SEQ_IDLE;
          end else begin
            re              = 1'b1;
            raddr           = emit_index + 1'b1;
            emit_index_next = emit_index + 1'b1;
          end
        end
      end
      default: begin
        seq_next = ffd_pkg::SEQ_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_hdr_starts_frame: assert property (@(posedge clk) disable iff (rst)
    (rx_valid && !rx_stall && phase == ffd_pkg::PH_WAIT_HDR1 &&
     rx_byte == ffd_pkg::HDR1_BYTE)
    |=> (phase == ffd_pkg::PH_COLLECT && fill_index == ffd_pkg::addr_t'(2) &&
         running_sum == 8'd0))
    else $error("frame start did not set up collection");

  a_replay_holds_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_status == ffd_pkg::ST_VALID && !last)
    |-> (seq != ffd_pkg::SEQ_IDLE && rx_stall))
    else $error("input taken in the middle of a frame replay");

  a_replay_order: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && frame_status == ffd_pkg::ST_VALID && !last)
    |=> (res_valid && frame_status == ffd_pkg::ST_VALID &&
         byte_index == $past(byte_index) + 1'b1) || !res_valid)
    else $error("replayed beat out of order");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the fixed frame deframer with sum check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEM_TARGET = 300;
  localparam int unsigned CALM_AFTER  = 240;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic [7:0] OPENING [13] = '{
    8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'hAA, 8'hFF,
    8'hAA, 8'hAA, 8'hAA, 8'h54, 8'hAA, 8'h56
  };

  typedef enum int {
    FK_GOOD,
    FK_BAD_TYPE,
    FK_BAD_LEN,
    FK_BAD_TAIL,
    FK_BAD_SUM
  } frame_kind_t;

  typedef struct {
    logic [1:0]                  status;
    logic [7:0]                  data;
    logic [ffd_pkg::INDEX_W-1:0] index;
    logic                        last;
  } beat_t;

  class deframer_model;
    ffd_pkg::sync_phase_t phase;
    int unsigned fill;
    logic [7:0]  sum;
    logic [7:0]  store [ffd_pkg::FRAME_BYTES];
    beat_t       due [$];
    int unsigned errors;
    int unsigned matched;
    int unsigned good_frames;
    int unsigned bad_frames;

    function new();
      phase = ffd_pkg::PH_HUNT;
      fill = 0;
      sum = 8'h00;
      errors = 0;
      matched = 0;
      good_frames = 0;
      bad_frames = 0;
    endfunction

    function void push(logic [1:0] st, logic [7:0] d, int unsigned idx, logic lst);
      beat_t t;
      t.status = st;
      t.data = d;
      t.index = ffd_pkg::INDEX_W'(idx);
      t.last = lst;
      due.push_back(t);
    endfunction

    function void take_rx_byte(logic [7:0] b);
      bit done;
      int unsigned k;
      done = 0;
      case (phase)
        ffd_pkg::PH_HUNT: begin
          if (b == ffd_pkg::HDR0_BYTE) begin
            store[0] = b;
            phase = ffd_pkg::PH_WAIT_HDR1;
          end
        end
        ffd_pkg::PH_WAIT_HDR1: begin
          if (b == ffd_pkg::HDR1_BYTE) begin
            store[1] = b;
            fill = 2;
            sum = 8'h00;
            phase = ffd_pkg::PH_COLLECT;
          end else if (b != ffd_pkg::HDR0_BYTE) begin
            phase = ffd_pkg::PH_HUNT;
          end
        end
        ffd_pkg::PH_COLLECT: begin
          store[fill] = b;
          if (fill >= 2 && fill <= ffd_pkg::FRAME_BYTES - 3) sum += b;
          if (fill == ffd_pkg::FRAME_BYTES - 1) begin
            phase = ffd_pkg::PH_HUNT;
            fill = 0;
            done = 1;
            if (store[2] == ffd_pkg::TYPE_BYTE && store[3] == ffd_pkg::LEN_BYTE &&
                store[ffd_pkg::FRAME_BYTES-1] == ffd_pkg::TAIL_BYTE &&
                sum == store[ffd_pkg::FRAME_BYTES-2]) begin
              for (k = 0; k < ffd_pkg::FRAME_BYTES; k++)
                push(ffd_pkg::ST_VALID, store[k], k, k == ffd_pkg::FRAME_BYTES - 1);
              good_frames++;
            end else begin
              push(ffd_pkg::ST_INVALID, 8'h00, 0, 1'b1);
              bad_frames++;
            end
          end else begin
            fill++;
          end
        end
        default: phase = ffd_pkg::PH_HUNT;
      endcase
      if (!done) push(ffd_pkg::ST_PENDING, 8'h00, 0, 1'b1);
    endfunction

    function void match_beat(logic [1:0] st, logic [7:0] d,
                             logic [ffd_pkg::INDEX_W-1:0] idx, logic lst);
      beat_t want;
      if (due.size() == 0) begin
        errors++;
        $error("Unexpected result beat: status %0d, byte %02h, index %0d, last %0b.",
               st, d, idx, lst);
        return;
      end
      want = due.pop_front();
      matched++;
      if (st !== want.status) begin
        errors++;
        $error("frame_status: expected %0d, actual %0d", want.status, st);
      end
      if (d !== want.data) begin
        errors++;
        $error("frame_byte: expected %02h, actual %02h", want.data, d);
      end
      if (idx !== want.index) begin
        errors++;
        $error("byte_index: expected %0d, actual %0d", want.index, idx);
      end
      if (lst !== want.last) begin
        errors++;
        $error("last: expected %0b, actual %0b", want.last, lst);
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        rx_valid = 1'b0;
  logic                        rx_stall;
  logic [7:0]                  rx_byte = 8'h00;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  logic [1:0]                  frame_status;
  logic [7:0]                  frame_byte;
  logic [ffd_pkg::INDEX_W-1:0] byte_index;
  logic                        last;

  deframer_model sb;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;
  int unsigned   sent = 0;
  int unsigned   cycles = 0;

  fixed_frame_deframer_sum_check_unit dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .frame_status (frame_status),
    .frame_byte   (frame_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (sent >= CALM_AFTER) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      rx_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    sb.take_rx_byte(b);
    sent++;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  f [ffd_pkg::FRAME_BYTES];
    logic [7:0]  s;
    int unsigned i;
    int unsigned lead;
    lead = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
    f[0] = ffd_pkg::HDR0_BYTE;
    f[1] = ffd_pkg::HDR1_BYTE;
    f[2] = ffd_pkg::TYPE_BYTE;
    f[3] = ffd_pkg::LEN_BYTE;
    for (i = 4; i < ffd_pkg::FRAME_BYTES - 2; i++) begin
      case ($urandom_range(0, 9))
        0: f[i] = ffd_pkg::HDR0_BYTE;
        1: f[i] = ffd_pkg::HDR1_BYTE;
        default: f[i] = 8'($urandom);
      endcase
    end
    f[ffd_pkg::FRAME_BYTES-1] = ffd_pkg::TAIL_BYTE;
    case (kind)
      FK_BAD_TYPE: f[2] = ffd_pkg::TYPE_BYTE ^ 8'($urandom_range(1, 255));
      FK_BAD_LEN: f[3] = ffd_pkg::LEN_BYTE ^ 8'($urandom_range(1, 255));
      FK_BAD_TAIL: f[ffd_pkg::FRAME_BYTES-1] = ffd_pkg::TAIL_BYTE ^
                                                8'($urandom_range(1, 255));
      default: ;
    endcase
    s = 8'h00;
    for (i = 2; i <= ffd_pkg::FRAME_BYTES - 3; i++) s += f[i];
    f[ffd_pkg::FRAME_BYTES-2] = (kind == FK_BAD_SUM) ? s + 8'($urandom_range(1, 255)) : s;
    repeat (lead) send_byte(ffd_pkg::HDR0_BYTE);
    for (i = 0; i < ffd_pkg::FRAME_BYTES; i++) send_byte(f[i]);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) send_byte($urandom_range(0, 3) == 0 ? ffd_pkg::HDR0_BYTE : 8'($urandom));
  endtask

  initial begin
    int unsigned run;
    int unsigned hold_left;
    hold_left = 0;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (run > 0) begin
        run--;
        res_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        run = $urandom_range(1, 18) - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.match_beat(frame_status, frame_byte, byte_index, last);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d beats outstanding.", sb.due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned seq;
    frame_kind_t kind;
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) send_byte(OPENING[i]);

    seq = 0;
    while (sent < ITEM_TARGET) begin
      if (seq < 5 || $urandom_range(0, 3) != 0) begin
        if (seq < 5)
          kind = frame_kind_t'(seq);
        else
          kind = $urandom_range(0, 1) ? FK_GOOD : frame_kind_t'($urandom_range(1, 4));
        if (seq == 0) hold_req = 1'b1;
        send_frame(kind);
      end else begin
        send_noise();
      end
      seq++;
    end

    @(negedge clk);
    rx_valid <= 1'b0;
    idle_on = 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (ffd_pkg::FRAME_BYTES + 8) @(posedge clk);

    $display("Fed %0d bytes covering header hunting, %0d replayed frames and %0d rejected.",
             sent, sb.good_frames, sb.bad_frames);
    $display("Compared %0d result beats and found %0d field mismatches.",
             sb.matched, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ffd_pkg.sv
hw/rtl/fixed_frame_deframer_sum_check_unit.sv
dv/testbench.sv
